// ===== rtl/core/rndg_pkg.sv =====
// ----------------------------------------------------------------------------
// rndg_pkg: shared types, constants and functions
// Sizes, register indexes and the grayscale arithmetic for the
// nearest-neighbor RGB565 to grayscale downscaler.
// ----------------------------------------------------------------------------
package rndg_pkg;

   // Output frame is OUT_SIZE x OUT_SIZE; OUT_SIZE is a power of two (at most 64 with IDX_W = 12)
   localparam int OUT_LOG  = 6;
   localparam int OUT_SIZE = 1 << OUT_LOG;
   localparam int OCNT_W   = OUT_LOG + 1;

   // Field and register widths
   localparam int SRC_W    = 10;
   localparam int SUM_W    = SRC_W + OUT_LOG + 1;
   localparam int IDX_W    = 12;
   localparam int GRAY_W   = 8;
   localparam int WSUM_W   = 15;
   localparam int CSR_IDX_W = 1;

   localparam logic [SRC_W-1:0] SRC_MAX      = {SRC_W{1'b1}};
   localparam logic [SRC_W-1:0] WIDTH_RESET  = SRC_W'(160);
   localparam logic [SRC_W-1:0] HEIGHT_RESET = SRC_W'(120);
   localparam logic [IDX_W-1:0] LAST_INDEX   = IDX_W'(OUT_SIZE * OUT_SIZE - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   // Luma weights, and x/100 as (x*DIV_MUL) >> DIV_SHIFT, exact for x < 2^15
   localparam int W_RED    = 30;
   localparam int W_GREEN  = 59;
   localparam int W_BLUE   = 11;
   localparam int DIV_MUL  = 5243;
   localparam int DIV_SHIFT = 19;
   localparam int PROD_W   = WSUM_W + 13;

   // Sample decision handed from the sampler to the pipeline
   typedef struct packed {
      logic             emit;
      logic [IDX_W-1:0] index;
      logic             last;
   } samp_type;

   // Expand RGB565 bytes and form the weighted sum 30r + 59g + 11b
   function automatic logic [WSUM_W-1:0] weighted_sum(input logic [7:0] lo,
                                                      input logic [7:0] hi);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = {hi[7:3], 3'b000};
      g = {hi[2:0], lo[7:5], 2'b00};
      b = {lo[4:0], 3'b000};
      return WSUM_W'(r * WSUM_W'(W_RED)) + WSUM_W'(g * WSUM_W'(W_GREEN))
           + WSUM_W'(b * WSUM_W'(W_BLUE));
   endfunction

   // Divide the weighted sum by 100 through a reciprocal multiply
   function automatic logic [GRAY_W-1:0] div100(input logic [WSUM_W-1:0] x);
      logic [PROD_W-1:0] p;
      p = PROD_W'(x) * PROD_W'(DIV_MUL);
      return p[DIV_SHIFT +: GRAY_W];
   endfunction

endpackage

// ===== rtl/core/rndg_sampler.sv =====
// ----------------------------------------------------------------------------
// rndg_sampler: source position tracking and sample selection
// Follows the raster position of the incoming pixels and decides, per
// pixel, whether it lands on an output grid point.
// ----------------------------------------------------------------------------
module rndg_sampler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             frame_start,
   input  logic [rndg_pkg::SRC_W-1:0]       source_width,
   input  logic [rndg_pkg::SRC_W-1:0]       source_height,
   output rndg_pkg::samp_type               samp
);

   logic [rndg_pkg::SRC_W-1:0]  scol_ff, scol_in, c_scol;
   logic [rndg_pkg::SRC_W-1:0]  srow_ff, srow_in, c_srow;
   logic [rndg_pkg::OCNT_W-1:0] ocol_ff, ocol_in, c_ocol;
   logic [rndg_pkg::OCNT_W-1:0] orow_ff, orow_in, c_orow;
   logic [rndg_pkg::SUM_W-1:0]  csum_ff, csum_in, c_csum;
   logic [rndg_pkg::SUM_W-1:0]  rsum_ff, rsum_in, c_rsum;
   logic [rndg_pkg::SRC_W-1:0]  eff_w, eff_h;
   logic                        row_hit, col_hit, line_end;
   logic [rndg_pkg::SUM_W-1:0]  col_target, row_target;

   // Clamp sizes below the output size up to it
   assign eff_w = (source_width < rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE))
                ? rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE) : source_width;
   assign eff_h = (source_height < rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE))
                ? rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE) : source_height;

   // Frame start restarts all counters for this beat
   assign c_scol = frame_start ? '0 : scol_ff;
   assign c_srow = frame_start ? '0 : srow_ff;
   assign c_ocol = frame_start ? '0 : ocol_ff;
   assign c_orow = frame_start ? '0 : orow_ff;
   assign c_csum = frame_start ? '0 : csum_ff;
   assign c_rsum = frame_start ? '0 : rsum_ff;

   // Target source position is the running product divided by the output size
   assign col_target = c_csum >> rndg_pkg::OUT_LOG;
   assign row_target = c_rsum >> rndg_pkg::OUT_LOG;

   assign row_hit = (c_orow < rndg_pkg::OCNT_W'(rndg_pkg::OUT_SIZE))
                 && (rndg_pkg::SUM_W'(c_srow) == row_target);
   assign col_hit = (c_ocol < rndg_pkg::OCNT_W'(rndg_pkg::OUT_SIZE))
                 && (rndg_pkg::SUM_W'(c_scol) == col_target);
   assign line_end = (c_scol >= eff_w - rndg_pkg::SRC_W'(1));

   // Sample decision for the current beat
   always_comb begin
      samp.emit  = col_hit && row_hit;
      samp.index = rndg_pkg::IDX_W'(
                      ((rndg_pkg::IDX_W + rndg_pkg::OCNT_W)'(c_orow) << rndg_pkg::OUT_LOG)
                      + (rndg_pkg::IDX_W + rndg_pkg::OCNT_W)'(c_ocol));
      samp.last  = (c_orow == rndg_pkg::OCNT_W'(rndg_pkg::OUT_SIZE - 1))
                && (c_ocol == rndg_pkg::OCNT_W'(rndg_pkg::OUT_SIZE - 1));
   end

   // Advance the column and row counters
   always_comb begin
      ocol_in = c_ocol;
      csum_in = c_csum;
      orow_in = c_orow;
      rsum_in = c_rsum;
      srow_in = c_srow;
      scol_in = c_scol + rndg_pkg::SRC_W'(1);
      if (col_hit) begin
         ocol_in = c_ocol + rndg_pkg::OCNT_W'(1);
         csum_in = c_csum + rndg_pkg::SUM_W'(eff_w);
      end
      if (line_end) begin
         scol_in = '0;
         ocol_in = '0;
         csum_in = '0;
         if (row_hit) begin
            orow_in = c_orow + rndg_pkg::OCNT_W'(1);
            rsum_in = c_rsum + rndg_pkg::SUM_W'(eff_h);
         end
         if (c_srow != rndg_pkg::SRC_MAX) begin
            srow_in = c_srow + rndg_pkg::SRC_W'(1);
         end
      end
   end

   // Hold counters unless a beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         scol_ff <= '0;
         srow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         csum_ff <= '0;
         rsum_ff <= '0;
      end else if (advance) begin
         scol_ff <= scol_in;
         srow_ff <= srow_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         csum_ff <= csum_in;
         rsum_ff <= rsum_in;
      end
   end

endmodule

// ===== rtl/core/rgb565_nearest_downscale_gray.sv =====
// ----------------------------------------------------------------------------
// rgb565_nearest_downscale_gray: RGB565 stream to 64x64 grayscale
// Samples a raster pixel stream by nearest neighbor onto a fixed output
// grid and converts each sampled pixel to 8-bit gray.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  pixel_low_byte, pixel_high_byte,
//                                            frame_start
//   rsp      out        rsp_valid/rsp_ready  gray_value, output_index, frame_done
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One pixel is taken per clock while req_ready is high. A sampled pixel goes
// through the weighted sum register, then the reciprocal divide into the output
// register, then to rsp. Reset clears position counters and loads 160x120.
// With rsp stalled, two results are held and req_ready drops only when both
// the sum stage and the output register are full.
// ----------------------------------------------------------------------------
module rgb565_nearest_downscale_gray (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_pixel_low_byte,
   input  logic [7:0]                          req_pixel_high_byte,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rndg_pkg::GRAY_W-1:0]         rsp_gray_value,
   output logic [rndg_pkg::IDX_W-1:0]          rsp_output_index,
   output logic                                rsp_frame_done,
   input  logic                                csr_write_enable,
   input  logic [rndg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rndg_pkg::SRC_W-1:0]          csr_write_data
);

   logic [rndg_pkg::SRC_W-1:0]  width_ff, height_ff;
   rndg_pkg::samp_type          samp;
   logic                        accept, out_free, s1_move;
   logic                        s1_valid_ff, s1_valid_in;
   logic [rndg_pkg::WSUM_W-1:0] s1_sum_ff;
   logic [rndg_pkg::IDX_W-1:0]  s1_index_ff;
   logic                        s1_last_ff;
   logic                        rsp_valid_ff;
   logic [rndg_pkg::GRAY_W-1:0] gray_ff;
   logic [rndg_pkg::IDX_W-1:0]  index_ff;
   logic                        done_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rndg_pkg::WIDTH_RESET;
         height_ff <= rndg_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rndg_pkg::CSR_SOURCE_WIDTH:  width_ff  <= csr_write_data;
            rndg_pkg::CSR_SOURCE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   rndg_sampler u_sampler (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .frame_start   (req_frame_start),
      .source_width  (width_ff),
      .source_height (height_ff),
      .samp          (samp)
   );

   // Sum stage: load on a sampled beat, drop when passed on
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = samp.emit;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && samp.emit) begin
         s1_sum_ff   <= rndg_pkg::weighted_sum(req_pixel_low_byte, req_pixel_high_byte);
         s1_index_ff <= samp.index;
         s1_last_ff  <= samp.last;
      end
   end

   // Output register: divide by 100 on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         gray_ff  <= rndg_pkg::div100(s1_sum_ff);
         index_ff <= s1_index_ff;
         done_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gray_value   = gray_ff;
   assign rsp_output_index = index_ff;
   assign rsp_frame_done   = done_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while a stage was free");

   a_no_emit_leaves_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && !samp.emit) |=> !s1_valid_ff)
      else $error("sum stage loaded on a pixel that is not sampled");

   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("result lost between sum stage and output register");

   a_done_on_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_done) |-> (rsp_output_index == rndg_pkg::LAST_INDEX))
      else $error("frame_done on a pixel other than the last");

endmodule

// ===== tb/downscale_checker.sv =====
// ----------------------------------------------------------------------------
// downscale_checker: gray result predictor and comparator
// Watches the pixel, result and register ports of the downscaler. It keeps
// its own sampling counters and size registers, queues the gray result that
// each accepted pixel beat implies, and compares every result beat, field
// by field, with the oldest queued entry.
// ----------------------------------------------------------------------------
module downscale_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [7:0]                          req_pixel_low_byte,
   input  logic [7:0]                          req_pixel_high_byte,
   input  logic                                req_frame_start,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [rndg_pkg::GRAY_W-1:0]         rsp_gray_value,
   input  logic [rndg_pkg::IDX_W-1:0]          rsp_output_index,
   input  logic                                rsp_frame_done,
   input  logic                                csr_write_enable,
   input  logic [rndg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rndg_pkg::SRC_W-1:0]          csr_write_data,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  pixel_beats,
   output int                                  gray_beats,
   output int                                  frame_ends
);

   localparam int GRAY_DIVISOR = 100;

   typedef struct packed {
      logic [rndg_pkg::GRAY_W-1:0] gray;
      logic [rndg_pkg::IDX_W-1:0]  index;
      logic                        done;
   } gray_pixel_type;

   gray_pixel_type expected_gray[$];

   // Own copy of the size registers and the sampling counters
   logic [rndg_pkg::SRC_W-1:0]  width_reg;
   logic [rndg_pkg::SRC_W-1:0]  height_reg;
   logic [rndg_pkg::SRC_W-1:0]  src_col;
   logic [rndg_pkg::SRC_W-1:0]  src_row;
   logic [rndg_pkg::OCNT_W-1:0] out_col;
   logic [rndg_pkg::OCNT_W-1:0] out_row;
   logic [rndg_pkg::SUM_W-1:0]  col_sum;
   logic [rndg_pkg::SUM_W-1:0]  row_sum;

   // Expand RGB565 to 8-bit channels and weight them into gray
   function automatic logic [rndg_pkg::GRAY_W-1:0] gray_of_rgb565(input logic [7:0] lo,
                                                                  input logic [7:0] hi);
      int red;
      int green;
      int blue;
      red   = {hi[7:3], 3'b000};
      green = {hi[2:0], lo[7:5], 2'b00};
      blue  = {lo[4:0], 3'b000};
      return rndg_pkg::GRAY_W'((red * rndg_pkg::W_RED + green * rndg_pkg::W_GREEN
                                + blue * rndg_pkg::W_BLUE) / GRAY_DIVISOR);
   endfunction

   // Sizes below the output grid act as the grid size
   function automatic logic [rndg_pkg::SRC_W-1:0] clamp_size(
         input logic [rndg_pkg::SRC_W-1:0] v);
      return (v < rndg_pkg::OUT_SIZE) ? rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE) : v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Advance the sampler by one source pixel and queue its result, if any
   task automatic sample_pixel(input logic [7:0] lo, input logic [7:0] hi,
                               input logic start);
      logic [rndg_pkg::SRC_W-1:0] w;
      logic [rndg_pkg::SRC_W-1:0] h;
      logic                       row_hit;
      logic                       col_hit;
      gray_pixel_type             res;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      if (start) begin
         src_col = '0;
         src_row = '0;
         out_col = '0;
         out_row = '0;
         col_sum = '0;
         row_sum = '0;
      end
      row_hit = (out_row < rndg_pkg::OUT_SIZE)
             && (rndg_pkg::SUM_W'(src_row) == (row_sum >> rndg_pkg::OUT_LOG));
      col_hit = (out_col < rndg_pkg::OUT_SIZE)
             && (rndg_pkg::SUM_W'(src_col) == (col_sum >> rndg_pkg::OUT_LOG));
      if (col_hit) begin
         if (row_hit) begin
            res.gray  = gray_of_rgb565(lo, hi);
            res.index = rndg_pkg::IDX_W'(int'(out_row) * rndg_pkg::OUT_SIZE + int'(out_col));
            res.done  = (out_row == rndg_pkg::OUT_SIZE - 1)
                     && (out_col == rndg_pkg::OUT_SIZE - 1);
            expected_gray.push_back(res);
         end
         out_col = out_col + 1'b1;
         col_sum = col_sum + rndg_pkg::SUM_W'(w);
      end
      // Close the line at the last column, or past it after a width cut
      if (src_col >= w - 1'b1) begin
         src_col = '0;
         out_col = '0;
         col_sum = '0;
         if (row_hit) begin
            out_row = out_row + 1'b1;
            row_sum = row_sum + rndg_pkg::SUM_W'(h);
         end
         if (src_row != rndg_pkg::SRC_MAX) src_row = src_row + 1'b1;
      end else begin
         src_col = src_col + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch_ports
      gray_pixel_type want;
      if (reset) begin
         expected_gray.delete();
         width_reg  = rndg_pkg::WIDTH_RESET;
         height_reg = rndg_pkg::HEIGHT_RESET;
         src_col    = '0;
         src_row    = '0;
         out_col    = '0;
         out_row    = '0;
         col_sum    = '0;
         row_sum    = '0;
      end else begin
         // Compare each result beat with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            gray_beats++;
            if (rsp_frame_done) frame_ends++;
            if (expected_gray.size() == 0) begin
               report_mismatch($sformatf("unexpected result: index %0d gray %0d",
                                         rsp_output_index, rsp_gray_value));
            end else begin
               want = expected_gray.pop_front();
               if (rsp_gray_value !== want.gray)
                  report_mismatch($sformatf("index %0d: gray %0d, expected %0d",
                                            want.index, rsp_gray_value, want.gray));
               if (rsp_output_index !== want.index)
                  report_mismatch($sformatf("output index %0d, expected %0d",
                                            rsp_output_index, want.index));
               if (rsp_frame_done !== want.done)
                  report_mismatch($sformatf("index %0d: frame_done %0b, expected %0b",
                                            want.index, rsp_frame_done, want.done));
            end
         end
         // Predict from each pixel beat with the sizes in force before any write
         if (req_valid && req_ready) begin
            pixel_beats++;
            sample_pixel(req_pixel_low_byte, req_pixel_high_byte, req_frame_start);
         end
         if (csr_write_enable) begin
            case (csr_index)
               rndg_pkg::CSR_SOURCE_WIDTH:  width_reg  = csr_write_data;
               rndg_pkg::CSR_SOURCE_HEIGHT: height_reg = csr_write_data;
               default: ;
            endcase
         end
      end
      pending = expected_gray.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for rgb565_nearest_downscale_gray
// Drives pixel beats and size register writes, varies idling on both
// channels, and leaves prediction and comparison to downscale_checker.
// Covers the widest and tallest sources, clamped sizes, a line end,
// mid-line width cuts, restarts and random frame segments.
// ----------------------------------------------------------------------------
module testbench;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int LATENCY_GAP  = 4;
   localparam int BUSY_PCT     = 68;
   localparam int LIGHT_PCT    = 25;
   localparam int RANDOM_ITEMS = 150;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [7:0]                          req_pixel_low_byte;
   logic [7:0]                          req_pixel_high_byte;
   logic                                req_frame_start;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [rndg_pkg::GRAY_W-1:0]         rsp_gray_value;
   logic [rndg_pkg::IDX_W-1:0]          rsp_output_index;
   logic                                rsp_frame_done;
   logic                                csr_write_enable;
   logic [rndg_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [rndg_pkg::SRC_W-1:0]          csr_write_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches;
   int pending;
   int pixel_beats;
   int gray_beats;
   int frame_ends;
   int random_items;
   int segment_len;

   rgb565_nearest_downscale_gray dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_low_byte  (req_pixel_low_byte),
      .req_pixel_high_byte (req_pixel_high_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_gray_value      (rsp_gray_value),
      .rsp_output_index    (rsp_output_index),
      .rsp_frame_done      (rsp_frame_done),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   downscale_checker gray_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_low_byte  (req_pixel_low_byte),
      .req_pixel_high_byte (req_pixel_high_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_gray_value      (rsp_gray_value),
      .rsp_output_index    (rsp_output_index),
      .rsp_frame_done      (rsp_frame_done),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatches          (mismatches),
      .pending             (pending),
      .pixel_beats         (pixel_beats),
      .gray_beats          (gray_beats),
      .frame_ends          (frame_ends)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result channel at the rate of the current phase
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stop a hung run
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $display("Timeout with %0d results still expected", pending);
      $finish;
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = BUSY_PCT;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = BUSY_PCT;
         end
         default: begin
            send_idle_pct  = LIGHT_PCT;
            recv_stall_pct = LIGHT_PCT;
         end
      endcase
   endtask

   // Offer one pixel beat after random idle cycles and hold it until taken
   task automatic send_pixel(input logic [7:0] lo, input logic [7:0] hi,
                             input logic start);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_pixel_low_byte  <= lo;
      req_pixel_high_byte <= hi;
      req_frame_start     <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off pixels until every expected result is out and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY_GAP) @(negedge clock);
   endtask

   task automatic set_source_size(input logic [rndg_pkg::SRC_W-1:0] w,
                                  input logic [rndg_pkg::SRC_W-1:0] h);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= rndg_pkg::CSR_SOURCE_WIDTH;
      csr_write_data   <= w;
      @(negedge clock);
      csr_index        <= rndg_pkg::CSR_SOURCE_HEIGHT;
      csr_write_data   <= h;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random pixels; optionally open a frame and sprinkle stray restarts
   task automatic send_random_pixels(input int count, input bit open_frame,
                                     input bit noise);
      logic start;
      for (int i = 0; i < count; i++) begin
         start = (i == 0 && open_frame) || (noise && $urandom_range(199) == 0);
         send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), start);
      end
   endtask

   // Mostly sizes near the grid, sometimes clamped or the widest
   function automatic logic [rndg_pkg::SRC_W-1:0] pick_size();
      case ($urandom_range(9))
         0:       return rndg_pkg::SRC_W'($urandom_range(63));
         1:       return rndg_pkg::SRC_MAX;
         default: return rndg_pkg::SRC_W'($urandom_range(64, 140));
      endcase
   endfunction

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_pixel_low_byte  = '0;
      req_pixel_high_byte = '0;
      req_frame_start     = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = rndg_pkg::CSR_SOURCE_WIDTH;
      csr_write_data      = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset sizes: black at the origin, white on the next sampled column
      set_idle_mode(IDLE_NONE);
      send_pixel(8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 1'b0);
      send_pixel(8'hFF, 8'hFF, 1'b0);

      // Clamped sizes: every pixel sampled; pure channels and a mid-frame restart
      set_source_size(rndg_pkg::SRC_W'(0), rndg_pkg::SRC_W'(63));
      send_pixel(8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h1F, 8'h00, 1'b0);
      send_pixel(8'hE0, 8'h07, 1'b0);
      send_pixel(8'h00, 8'hF8, 1'b0);
      send_pixel(8'hE0, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h07, 1'b0);
      send_pixel(8'h55, 8'hAA, 1'b0);
      send_pixel(8'hAA, 8'h55, 1'b0);
      send_pixel(8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h12, 8'h34, 1'b0);

      // Largest sizes: only about every sixteenth column is taken
      set_source_size(rndg_pkg::SRC_MAX, rndg_pkg::SRC_MAX);
      send_pixel(8'hFF, 8'hFF, 1'b1);
      for (int i = 0; i < 16; i++) send_pixel(8'($urandom_range(255)), 8'h00, 1'b0);

      // Wide line across a line end into the next sampled row
      set_source_size(rndg_pkg::SRC_W'(150), rndg_pkg::SRC_W'(0));
      set_idle_mode(IDLE_SENDER);
      send_random_pixels(160, 1'b1, 1'b0);

      // Tallest frame on the narrowest lines
      set_source_size(rndg_pkg::SRC_W'(0), rndg_pkg::SRC_MAX);
      set_idle_mode(IDLE_RECEIVER);
      send_random_pixels(130, 1'b1, 1'b0);

      // Cut the width below the current column in the middle of a line
      set_source_size(rndg_pkg::SRC_W'(200), rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE));
      set_idle_mode(IDLE_BOTH);
      send_random_pixels(150, 1'b1, 1'b0);
      set_source_size(rndg_pkg::SRC_W'(100), rndg_pkg::SRC_W'(rndg_pkg::OUT_SIZE));
      send_random_pixels(60, 1'b0, 1'b0);

      // Random segments: mostly fresh frames, some continuing or restarted
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         segment_len = $urandom_range(40, 100);
         if ($urandom_range(9) < 7) set_source_size(pick_size(), pick_size());
         else drain_results();
         set_idle_mode(idle_mode_type'($urandom_range(3)));
         send_random_pixels(segment_len, $urandom_range(99) < 85, 1'b1);
         random_items += segment_len;
      end

      drain_results();
      repeat (10) @(negedge clock);
      $display("Summary: %0d pixel beats sent, %0d gray beats checked, %0d frame ends",
               pixel_beats, gray_beats, frame_ends);
      $display("Sizes from clamped to 1023, line ends, width cuts, restarts, four idle mixes");
      if (mismatches == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rndg_pkg.sv
rtl/core/rndg_sampler.sv
rtl/core/rgb565_nearest_downscale_gray.sv
tb/downscale_checker.sv
tb/testbench.sv
